### sv/sbus_frame_decoder_with_switch_keys_assert.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef SBUS_FRAME_DECODER_WITH_SWITCH_KEYS_ASSERT_SVH
`define SBUS_FRAME_DECODER_WITH_SWITCH_KEYS_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SFD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sfd assertion failed");

// Next-cycle implication, disabled while in reset.
`define SFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

`endif

### sv/sfd_pkg.sv
// Shared types, constants and register codes of the frame decoder.
`default_nettype none
package sfd_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int COUNT_W     = $clog2(FRAME_BYTES + 2);
    localparam int NUM_CHAN    = 10;
    localparam int NUM_SW      = 6;
    localparam int RAW_W       = 11;
    localparam int CHAN_W      = 12;
    localparam int FLAGS_W     = 15;
    localparam int PAYLOAD_LO  = 1;
    localparam int PAYLOAD_HI  = 14;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int OUT_W       = 136;

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(FRAME_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_SAT  = COUNT_W'(FRAME_BYTES + 1);

    localparam logic [7:0] SYNC_HEADER = 8'h0F;
    localparam logic [7:0] SYNC_FOOTER = 8'h00;

    // switch position codes
    localparam logic [1:0] POS_UP  = 2'd0;
    localparam logic [1:0] POS_MID = 2'd1;
    localparam logic [1:0] POS_DN  = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_OFFSET    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWITCH_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SWITCH_HIGH_LIMIT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SWITCH_DEADZONE   = 2'd3;

    localparam logic [10:0]        CHANNEL_OFFSET_RST = 11'd1024;
    localparam logic signed [11:0] SWITCH_LOW_RST     = -12'sd660;
    localparam logic signed [11:0] SWITCH_HIGH_RST    = 12'sd660;
    localparam logic [9:0]         SWITCH_DEADZONE_RST = 10'd100;

    typedef logic [1:0]               pos_t;
    typedef logic signed [CHAN_W-1:0] chan_t;
    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [10:0]        channel_offset;
        logic signed [11:0] switch_low_limit;
        logic signed [11:0] switch_high_limit;
        logic [9:0]         switch_deadzone;
    } cfg_t;

    typedef struct packed {
        logic byte_valid;  // data byte accepted this cycle
        logic idle;        // line-idle event accepted this cycle
    } store_ctl_t;

endpackage
`default_nettype wire

### sv/sfd_frame_store.sv
// Byte collection: frame store, saturating byte count and frame check.
`default_nettype none
`include "sbus_frame_decoder_with_switch_keys_assert.svh"
module sfd_frame_store (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sfd_pkg::store_ctl_t ctl,
    input  wire logic [7:0]         rx_byte,
    output      logic               frame_ok,
    output      sfd_pkg::frame_t    frame
);
    import sfd_pkg::*;

    frame_t             frame_store_reg;
    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;

    always_comb begin
        byte_count_next = byte_count_reg;
        if (ctl.idle) begin
            byte_count_next = '0;
        end else if (ctl.byte_valid) begin
            if (byte_count_reg < COUNT_FULL) begin
                byte_count_next = byte_count_reg + COUNT_W'(1);
            end else begin
                byte_count_next = COUNT_SAT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    // entries are only read once a whole burst has landed, so no reset
    always_ff @(posedge aclk) begin
        if (ctl.byte_valid && !ctl.idle && (byte_count_reg < COUNT_FULL)) begin
            frame_store_reg[byte_count_reg] <= rx_byte;
        end
    end

    assign frame_ok = (byte_count_reg == COUNT_FULL)
                   && (frame_store_reg[0] == SYNC_HEADER)
                   && (frame_store_reg[FRAME_BYTES-1] == SYNC_FOOTER);
    assign frame   = frame_store_reg;

    `SFD_ASSERT_IMPL(a_count_bounded, aclk, aresetn, 1'b1, byte_count_reg <= COUNT_SAT)
    `SFD_ASSERT_NEXT(a_idle_clears, aclk, aresetn, ctl.idle, byte_count_reg == '0)
    `SFD_ASSERT_NEXT(a_sat_holds, aclk, aresetn,
        ctl.byte_valid && !ctl.idle && (byte_count_reg >= COUNT_FULL),
        byte_count_reg == COUNT_SAT)

endmodule
`default_nettype wire

### sv/sfd_decode.sv
// Frame unpack, offset subtract, switch classification and key flags.
`default_nettype none
module sfd_decode (
    input  wire sfd_pkg::frame_t                      frame,
    input  wire sfd_pkg::cfg_t                        cfg,
    input  wire sfd_pkg::pos_t [sfd_pkg::NUM_SW-1:0]  prev_pos,
    output      sfd_pkg::chan_t [sfd_pkg::NUM_CHAN-1:0] chan,
    output      sfd_pkg::pos_t [sfd_pkg::NUM_SW-1:0]  new_pos,
    output      logic [sfd_pkg::FLAGS_W-1:0]          key_flags
);
    import sfd_pkg::*;

    localparam int STREAM_W = (PAYLOAD_HI - PAYLOAD_LO + 1) * 8;

    logic [STREAM_W-1:0] stream;
    logic signed [12:0]  up_thr;
    logic signed [12:0]  dn_thr;

    // channels are packed LSB first starting at byte 1
    assign stream = frame[PAYLOAD_HI:PAYLOAD_LO];

    assign up_thr = $signed({cfg.switch_low_limit[11], cfg.switch_low_limit})
                  + $signed({3'b000, cfg.switch_deadzone});
    assign dn_thr = $signed({cfg.switch_high_limit[11], cfg.switch_high_limit})
                  - $signed({3'b000, cfg.switch_deadzone});

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            chan[k] = $signed({1'b0, stream[k*RAW_W +: RAW_W]})
                    - $signed({1'b0, cfg.channel_offset});
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_SW; s++) begin
            if ($signed({chan[4+s][CHAN_W-1], chan[4+s]}) <= up_thr) begin
                new_pos[s] = POS_UP;
            end else if ($signed({chan[4+s][CHAN_W-1], chan[4+s]}) >= dn_thr) begin
                new_pos[s] = POS_DN;
            end else begin
                new_pos[s] = POS_MID;
            end
        end
    end

    always_comb begin
        key_flags = '0;
        // switch A: level flag
        key_flags[0] = (new_pos[0] == POS_UP);
        key_flags[1] = (new_pos[0] == POS_MID);
        key_flags[2] = (new_pos[0] == POS_DN);
        // switches B..D: mid suppressed on the frame where the switch moves
        for (int s = 1; s < 4; s++) begin
            key_flags[3*s]     = (new_pos[s] == POS_UP);
            key_flags[3*s + 1] = (new_pos[s] == POS_MID) && (prev_pos[s] == POS_MID);
            key_flags[3*s + 2] = (new_pos[s] == POS_DN);
        end
        key_flags[12] = (new_pos[4] == POS_UP);
        key_flags[13] = (new_pos[4] == POS_DN);
        // switch F: up-to-down edge
        key_flags[14] = (prev_pos[5] == POS_UP) && (new_pos[5] == POS_DN);
    end

endmodule
`default_nettype wire

### sv/sbus_frame_decoder_with_switch_keys.sv
// Top level: SBUS frame decoder with switch key flags.
// Takes one item per clock: a received byte (s_tuser = 0) or a line-idle event
// (s_tuser = 1). Bytes are stored as they arrive; an idle event closes the burst
// and, if exactly 25 bytes came with a 0x0F header and 0x00 footer, yields one
// result on the m_ side on the next cycle: ten offset channels and 15 key flags
// (A up/mid/down, B, C, D likewise, E up/down, F up-to-down press). Other bursts
// give nothing and leave the switch history alone. Decode is a single
// combinational pass from the frame store into one output register, so the
// sustained rate is one item per cycle; input is held off only while a result
// sits in the output register and the sink is not ready. Configuration writes
// take effect on the next frame and should be made while no frame is pending.
`default_nettype none
`include "sbus_frame_decoder_with_switch_keys_assert.svh"
module sbus_frame_decoder_with_switch_keys (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input items
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]                        s_tuser,   // [0] req_type
    // result items
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [11:0] chan_0 ... [119:108] chan_9, [134:120] key_flags, [135] zero
    output      logic [sfd_pkg::OUT_W-1:0]         m_tdata,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [sfd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import sfd_pkg::*;

    cfg_t                    cfg_reg;
    pos_t [NUM_SW-1:0]       prev_pos_reg;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;

    store_ctl_t              ctl;
    logic                    accept;
    logic                    frame_ok;
    frame_t                  frame;
    chan_t [NUM_CHAN-1:0]    chan;
    pos_t [NUM_SW-1:0]       new_pos;
    logic [FLAGS_W-1:0]      key_flags;
    logic                    emit;
    logic [OUT_W-1:0]        out_word;

    assign s_tready       = !m_tvalid_reg || m_tready;
    assign accept         = s_tvalid && s_tready;
    assign ctl            = '{byte_valid: accept && !s_tuser[0], idle: accept && s_tuser[0]};
    assign emit           = ctl.idle && frame_ok;

    sfd_frame_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .rx_byte  (s_tdata),
        .frame_ok (frame_ok),
        .frame    (frame)
    );

    sfd_decode u_decode (
        .frame     (frame),
        .cfg       (cfg_reg),
        .prev_pos  (prev_pos_reg),
        .chan      (chan),
        .new_pos   (new_pos),
        .key_flags (key_flags)
    );

    always_comb begin
        out_word = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            out_word[k*CHAN_W +: CHAN_W] = chan[k];
        end
        out_word[NUM_CHAN*CHAN_W +: FLAGS_W] = key_flags;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_offset    <= CHANNEL_OFFSET_RST;
            cfg_reg.switch_low_limit  <= SWITCH_LOW_RST;
            cfg_reg.switch_high_limit <= SWITCH_HIGH_RST;
            cfg_reg.switch_deadzone   <= SWITCH_DEADZONE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_CHANNEL_OFFSET:    cfg_reg.channel_offset    <= cfg_wr_data[10:0];
                REG_SWITCH_LOW_LIMIT:  cfg_reg.switch_low_limit  <= $signed(cfg_wr_data);
                REG_SWITCH_HIGH_LIMIT: cfg_reg.switch_high_limit <= $signed(cfg_wr_data);
                REG_SWITCH_DEADZONE:   cfg_reg.switch_deadzone   <= cfg_wr_data[9:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pos_reg <= {POS_UP, POS_UP, POS_MID, POS_MID, POS_MID, POS_MID};
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                prev_pos_reg <= new_pos;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SFD_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_tvalid_reg && !m_tready, !s_tready)
    `SFD_ASSERT_NEXT(a_frame_gives_result, aclk, aresetn, emit, m_tvalid_reg)
    `SFD_ASSERT_IMPL(a_switch_a_onehot, aclk, aresetn, m_tvalid_reg,
        $onehot(m_tdata_reg[NUM_CHAN*CHAN_W +: 3]))
    `SFD_ASSERT_IMPL(a_switch_e_excl, aclk, aresetn, m_tvalid_reg,
        !(m_tdata_reg[NUM_CHAN*CHAN_W + 12] && m_tdata_reg[NUM_CHAN*CHAN_W + 13]))

endmodule
`default_nettype wire
